### rtl/rtcp_receiver_report_builder_defines.svh
// Assertion helpers for the receiver report builder.
`ifndef RTCP_RECEIVER_REPORT_BUILDER_DEFINES_SVH
`define RTCP_RECEIVER_REPORT_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrb assertion failed");

// Next-cycle implication, disabled while in reset.
`define RRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrb assertion failed");

`endif

### rtl/rrb_pkg.sv
package rrb_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned LOST_LO_W  = 24;
  localparam int unsigned IDX_W      = 3;
  // one quotient bit per cell
  localparam int unsigned DIV_STEPS  = FRAC_W;

  localparam logic [7:0]  HDR_BYTE0    = 8'h81;
  localparam logic [7:0]  PKT_TYPE_RR  = 8'd201;
  localparam logic [15:0] LEN_WORDS    = 16'd7;
  localparam logic [WORD_W-1:0] RR_HEADER = {HDR_BYTE0, PKT_TYPE_RR, LEN_WORDS};
  localparam logic [FRAC_W-1:0] FRAC_MAX  = '1;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_OWN_SSRC      = 2'd0,
    CFG_REPORTED_SSRC = 2'd1
  } cfg_reg_t;

  // packet word positions
  typedef enum logic [IDX_W-1:0] {
    W_HEADER   = 3'd0,
    W_OWN_SSRC = 3'd1,
    W_REP_SSRC = 3'd2,
    W_LOSS     = 3'd3,
    W_HIGHEST  = 3'd4,
    W_JITTER   = 3'd5,
    W_LSR      = 3'd6,
    W_DLSR     = 3'd7
  } word_pos_t;

  typedef struct packed {
    logic [WORD_W-1:0] highest_seq;
    logic [WORD_W-1:0] base_seq;
    logic [WORD_W-1:0] received_count;
    logic [WORD_W-1:0] jitter_value;
  } rrb_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] report_word;
    logic [IDX_W-1:0]  word_index;
    logic              last_word;
  } rrb_word_t;

  // payload carried along the divider chain
  typedef struct packed {
    logic [WORD_W-1:0]    rem;
    logic [WORD_W-1:0]    divisor;
    logic [FRAC_W-1:0]    quo;
    logic [LOST_LO_W-1:0] lost_lo;
    logic [WORD_W-1:0]    highest;
    logic [WORD_W-1:0]    jitter;
    logic                 force_zero;
    logic                 force_max;
  } rrb_cell_t;

  typedef struct packed {
    logic      valid;
    rrb_cell_t data;
  } rrb_stage_t;

endpackage

### rtl/rrb_prep.sv
// Front cell: expected and lost counts, divider setup.
module rrb_prep (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  rrb_pkg::rrb_req_t in_req,
  output rrb_pkg::rrb_stage_t stage_out
);

  logic                        valid_r;
  rrb_pkg::rrb_cell_t          data_r;
  rrb_pkg::rrb_cell_t          data_nxt;
  logic [rrb_pkg::WORD_W-1:0]  expected;
  logic [rrb_pkg::WORD_W-1:0]  lost;

  // expected = highest - base + 1 unless the sequence went backwards
  always_comb begin
    if (in_req.highest_seq >= in_req.base_seq) begin
      expected = in_req.highest_seq - in_req.base_seq + rrb_pkg::WORD_W'(1);
    end else begin
      expected = in_req.received_count;
    end
    lost = (expected > in_req.received_count) ? expected - in_req.received_count : '0;
  end

  // lost never exceeds expected: equal means everything lost (saturate)
  always_comb begin
    data_nxt.force_zero = (expected == '0);
    data_nxt.force_max  = (expected != '0) && (lost == expected);
    data_nxt.rem        = (data_nxt.force_max) ? '0 : lost;
    data_nxt.divisor    = expected;
    data_nxt.quo        = '0;
    data_nxt.lost_lo    = lost[rrb_pkg::LOST_LO_W-1:0];
    data_nxt.highest    = in_req.highest_seq;
    data_nxt.jitter     = in_req.jitter_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign stage_out.valid = valid_r;
  assign stage_out.data  = data_r;

endmodule

### rtl/rrb_div_cell.sv
// One restoring-division step: produces one fraction bit per cell.
module rrb_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  rrb_pkg::rrb_stage_t stage_in,
  output rrb_pkg::rrb_stage_t stage_out
);

  logic                        valid_r;
  rrb_pkg::rrb_cell_t          data_r;
  rrb_pkg::rrb_cell_t          data_nxt;
  logic [rrb_pkg::WORD_W:0]    rem2;
  logic [rrb_pkg::WORD_W:0]    div_ext;
  logic                        ge;

  // remainder stays below the divisor, so 2*rem fits in WORD_W+1 bits
  always_comb begin
    rem2     = {stage_in.data.rem, 1'b0};
    div_ext  = {1'b0, stage_in.data.divisor};
    ge       = (rem2 >= div_ext);
    data_nxt = stage_in.data;
    data_nxt.rem = ge ? rrb_pkg::WORD_W'(rem2 - div_ext) : rem2[rrb_pkg::WORD_W-1:0];
    data_nxt.quo = {stage_in.data.quo[rrb_pkg::FRAC_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign stage_out.valid = valid_r;
  assign stage_out.data  = data_r;

endmodule

### rtl/rrb_serializer.sv
// Holds one finished report and sends it out a word per cycle while out_ready is high.
module rrb_serializer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rrb_pkg::rrb_stage_t        stage_in,
  output logic                       take,
  input  logic [rrb_pkg::WORD_W-1:0] own_ssrc,
  input  logic [rrb_pkg::WORD_W-1:0] rep_ssrc,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rrb_pkg::rrb_word_t         out_data
);

  logic                        active_r;
  logic [rrb_pkg::IDX_W-1:0]   idx_r;
  logic [rrb_pkg::WORD_W-1:0]  loss_r;
  logic [rrb_pkg::WORD_W-1:0]  highest_r;
  logic [rrb_pkg::WORD_W-1:0]  jitter_r;
  logic [rrb_pkg::FRAC_W-1:0]  frac;
  logic                        at_last;

  assign at_last = (idx_r == rrb_pkg::W_DLSR);
  // free when empty or the final word leaves this cycle
  assign take    = !active_r || (out_ready && at_last);

  always_comb begin
    if (stage_in.data.force_zero) begin
      frac = '0;
    end else if (stage_in.data.force_max) begin
      frac = rrb_pkg::FRAC_MAX;
    end else begin
      frac = stage_in.data.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else if (take) begin
      active_r <= stage_in.valid;
      idx_r    <= '0;
    end else if (out_ready) begin
      idx_r    <= idx_r + rrb_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take && stage_in.valid) begin
      loss_r    <= {frac, stage_in.data.lost_lo};
      highest_r <= stage_in.data.highest;
      jitter_r  <= stage_in.data.jitter;
    end
  end

  // word select
  always_comb begin
    case (idx_r)
      rrb_pkg::W_HEADER:   out_data.report_word = rrb_pkg::RR_HEADER;
      rrb_pkg::W_OWN_SSRC: out_data.report_word = own_ssrc;
      rrb_pkg::W_REP_SSRC: out_data.report_word = rep_ssrc;
      rrb_pkg::W_LOSS:     out_data.report_word = loss_r;
      rrb_pkg::W_HIGHEST:  out_data.report_word = highest_r;
      rrb_pkg::W_JITTER:   out_data.report_word = jitter_r;
      default:             out_data.report_word = '0;
    endcase
    out_data.word_index = idx_r;
    out_data.last_word  = at_last;
  end

  assign out_valid = active_r;

endmodule

### rtl/rtcp_receiver_report_builder.sv
// RTCP receiver report builder. Each accepted request becomes one eight-word
// receiver report (header, own SSRC, reported SSRC, fraction/lost, highest
// sequence, jitter, LSR = 0, DLSR = 0), sent one word per cycle while out_ready
// is high, with its index and a last-word flag. The output side sets the rate.
// A request passes a setup cell and eight division cells (one fraction bit
// each) before reaching the serializer; up to nine further requests queue
// in the chain while a report drains. Configuration writes are always
// accepted and should be made only while no report is pending.
`include "rtcp_receiver_report_builder_defines.svh"

module rtcp_receiver_report_builder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rrb_pkg::rrb_req_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rrb_pkg::rrb_word_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [rrb_pkg::WORD_W-1:0] cfg_data
);

  logic [rrb_pkg::WORD_W-1:0] own_ssrc_r;
  logic [rrb_pkg::WORD_W-1:0] rep_ssrc_r;
  rrb_pkg::rrb_stage_t        chain [0:rrb_pkg::DIV_STEPS];
  logic                       take;
  logic                       adv;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ssrc_r <= '0;
      rep_ssrc_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rrb_pkg::CFG_OWN_SSRC:      own_ssrc_r <= cfg_data;
        rrb_pkg::CFG_REPORTED_SSRC: rep_ssrc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // the chain moves unless a finished report waits at its tail
  assign adv      = !(chain[rrb_pkg::DIV_STEPS].valid && !take);
  assign in_ready = adv;

  rrb_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_req    (in_data),
    .stage_out (chain[0])
  );

  for (genvar g = 0; g < rrb_pkg::DIV_STEPS; g++) begin : g_div
    rrb_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .stage_in  (chain[g]),
      .stage_out (chain[g+1])
    );
  end

  rrb_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage_in  (chain[rrb_pkg::DIV_STEPS]),
    .take      (take),
    .own_ssrc  (own_ssrc_r),
    .rep_ssrc  (rep_ssrc_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a report stalled at the chain tail holds its contents
  `RRB_ASSERT_NEXT(a_tail_hold, clk, rst_n, !adv, $stable(chain[rrb_pkg::DIV_STEPS]))
  // words of one report advance by one with no gap
  `RRB_ASSERT_NEXT(a_word_step, clk, rst_n, out_valid && out_ready && !out_data.last_word,
    out_valid && (out_data.word_index == $past(out_data.word_index) + 3'd1))
  // first word is always the fixed header
  `RRB_ASSERT_NOW(a_header, clk, rst_n, out_valid && (out_data.word_index == rrb_pkg::W_HEADER),
    out_data.report_word == rrb_pkg::RR_HEADER)

endmodule
